// ===== hw/rtl/wbf_pkg.sv =====
// ----------------------------------------------------------------------------
// wbf_pkg
// Types and constants shared by the watchdog blink/freeze controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wbf_pkg;

  localparam int unsigned PeriodWidth = 16;
  localparam int unsigned LimitWidth  = 8;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned CfgDataWidth = 16;
  localparam int unsigned ModeWidth   = 2;

  // Configuration register indexes.
  localparam logic [CfgIdxWidth-1:0] CfgWaitPeriod  = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CfgBlinkPeriod = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CfgBlinkLimit  = 2'd2;

  // Register values after reset.
  localparam logic [PeriodWidth-1:0] WaitPeriodRst  = 16'd16000;
  localparam logic [PeriodWidth-1:0] BlinkPeriodRst = 16'd4000;
  localparam logic [LimitWidth-1:0]  BlinkLimitRst  = 8'd20;

  // Mode codes as reported on the result word.
  localparam logic [ModeWidth-1:0] ModeCodeWaiting  = 2'd0;
  localparam logic [ModeWidth-1:0] ModeCodeBlinking = 2'd1;
  localparam logic [ModeWidth-1:0] ModeCodeFrozen   = 2'd2;

  typedef enum logic [2:0] {
    MODE_WAITING  = 3'b001,
    MODE_BLINKING = 3'b010,
    MODE_FROZEN   = 3'b100
  } mode_e;

  typedef struct packed {
    logic [PeriodWidth-1:0] wait_period;
    logic [PeriodWidth-1:0] blink_half;
    logic [LimitWidth-1:0]  blink_limit;
  } cfg_t;

  typedef struct packed {
    mode_e                  mode;
    logic                   button_prev;
    logic                   blink_phase;
    logic [LimitWidth-1:0]  blink_counter;
    logic [PeriodWidth-1:0] tick_counter;
    logic                   timeout_flag;
    logic                   green;
    logic                   red;
  } state_t;

  function automatic logic [ModeWidth-1:0] mode_code(input mode_e mode);
    logic [ModeWidth-1:0] code;
    case (mode)
      MODE_WAITING:  code = ModeCodeWaiting;
      MODE_BLINKING: code = ModeCodeBlinking;
      MODE_FROZEN:   code = ModeCodeFrozen;
      default:       code = ModeCodeFrozen;
    endcase
    return code;
  endfunction

endpackage

// ===== hw/rtl/wbf_step.sv =====
// ----------------------------------------------------------------------------
// wbf_step
// Next-state logic for one sample: timer advance, button release handling
// and the waiting / blinking / frozen mode machine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wbf_step (
  input  wbf_pkg::cfg_t   cfg_i,
  input  wbf_pkg::state_t state_i,
  input  logic            button_level_i,
  input  logic            tick_i,
  output wbf_pkg::state_t state_o
);

  logic [wbf_pkg::PeriodWidth-1:0] period;
  logic [wbf_pkg::LimitWidth-1:0]  blink_count_inc;
  wbf_pkg::state_t                 st_timer;
  wbf_pkg::state_t                 st_button;

  assign period = (state_i.mode == wbf_pkg::MODE_WAITING) ? cfg_i.wait_period
                                                          : cfg_i.blink_half;

  // Timer: the counter wraps once it has reached the period.
  always_comb begin
    st_timer = state_i;
    if (tick_i) begin
      if (state_i.tick_counter >= period) begin
        st_timer.tick_counter = '0;
        st_timer.timeout_flag = 1'b1;
      end else begin
        st_timer.tick_counter = state_i.tick_counter + 1'b1;
      end
    end
  end

  // A release restarts the timer while waiting and ends a blink phase.
  always_comb begin
    st_button = st_timer;
    if (button_level_i && !st_timer.button_prev) begin
      st_button.button_prev = 1'b1;
    end else if (!button_level_i && st_timer.button_prev) begin
      st_button.button_prev = 1'b0;
      case (st_timer.mode)
        wbf_pkg::MODE_WAITING: begin
          st_button.tick_counter = '0;
          st_button.timeout_flag = 1'b0;
        end
        wbf_pkg::MODE_BLINKING: begin
          st_button.red          = 1'b0;
          st_button.green        = 1'b1;
          st_button.mode         = wbf_pkg::MODE_WAITING;
          st_button.tick_counter = '0;
          st_button.timeout_flag = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  assign blink_count_inc = st_button.blink_counter + 1'b1;

  always_comb begin
    state_o = st_button;
    case (st_button.mode)
      wbf_pkg::MODE_WAITING: begin
        if (st_button.timeout_flag) begin
          state_o.green         = 1'b0;
          state_o.mode          = wbf_pkg::MODE_BLINKING;
          state_o.blink_counter = '0;
          state_o.timeout_flag  = 1'b0;
        end
      end
      wbf_pkg::MODE_BLINKING: begin
        if (st_button.timeout_flag) begin
          state_o.timeout_flag  = 1'b0;
          state_o.blink_phase   = ~st_button.blink_phase;
          state_o.red           = ~st_button.blink_phase;
          state_o.blink_counter = blink_count_inc;
          if (blink_count_inc >= cfg_i.blink_limit) begin
            state_o.mode = wbf_pkg::MODE_FROZEN;
            state_o.red  = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hw/rtl/watchdog_blink_freeze_fsm.sv =====
// A sample's result word is registered and offered in the cycle after it is accepted.
// Throughput: one sample per cycle unless the result stream stalls; the state update
// is a single compare and increment pass between the state and result registers.
// Reset: asynchronous, active low; clears the mode machine to waiting with green on,
// empties the result register and restores the register defaults.
// ----------------------------------------------------------------------------
// watchdog_blink_freeze_fsm
// Watchdog that waits for a timeout, blinks the red indicator a configured
// number of times and then freezes with red on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module watchdog_blink_freeze_fsm (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write port.
  input  logic                             cfg_we_i,
  input  logic [wbf_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [wbf_pkg::CfgDataWidth-1:0] cfg_wdata_i,
  // Sample stream.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,  // [0] button_level, [1] tick
  // Result stream.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [7:0]                       m_axis_tdata   // [0] green_on, [1] red_led,
                                                          // [3:2] mode
);

  wbf_pkg::cfg_t   cfg_q;
  wbf_pkg::state_t state_q;
  wbf_pkg::state_t state_d;
  logic            out_valid_q;
  logic [7:0]      out_data_q;
  logic            accept;

  // The result register frees up in the same cycle its word is taken.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wait_period <= wbf_pkg::WaitPeriodRst;
      cfg_q.blink_half  <= wbf_pkg::BlinkPeriodRst;
      cfg_q.blink_limit <= wbf_pkg::BlinkLimitRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        wbf_pkg::CfgWaitPeriod:  cfg_q.wait_period <= cfg_wdata_i;
        wbf_pkg::CfgBlinkPeriod: cfg_q.blink_half  <= cfg_wdata_i;
        wbf_pkg::CfgBlinkLimit:
          cfg_q.blink_limit <= cfg_wdata_i[wbf_pkg::LimitWidth-1:0];
        default: begin
        end
      endcase
    end
  end

  wbf_step u_step (
    .cfg_i          (cfg_q),
    .state_i        (state_q),
    .button_level_i (s_axis_tdata[0]),
    .tick_i         (s_axis_tdata[1]),
    .state_o        (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode          <= wbf_pkg::MODE_WAITING;
      state_q.button_prev   <= 1'b0;
      state_q.blink_phase   <= 1'b0;
      state_q.blink_counter <= '0;
      state_q.tick_counter  <= '0;
      state_q.timeout_flag  <= 1'b0;
      state_q.green         <= 1'b1;
      state_q.red           <= 1'b0;
      out_valid_q           <= 1'b0;
    end else begin
      if (accept) begin
        state_q <= state_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= {4'b0000, wbf_pkg::mode_code(state_d.mode), state_d.red, state_d.green};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the watchdog blink/freeze controller. A scoreboard
// object predicts the LED levels and mode for every accepted sample word and
// checks each result word in order. A short directed run covers the timer
// wrap corner cases, then random phases with different register settings
// and random idling on both sides drive the block into every mode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam logic [wbf_pkg::CfgIdxWidth-1:0] CfgUnusedIdx = 2'd3;
  localparam int StallLimit = 2000;
  localparam int NumPhases = 8;

  typedef struct packed {
    logic                          green;
    logic                          red;
    logic [wbf_pkg::ModeWidth-1:0] mode;
  } led_word_t;

  // Tracks the controller state and holds the LED words still owed by the block.
  class blink_checker;
    logic [wbf_pkg::PeriodWidth-1:0] wait_ticks;
    logic [wbf_pkg::PeriodWidth-1:0] blink_ticks;
    logic [wbf_pkg::LimitWidth-1:0]  toggle_limit;
    wbf_pkg::mode_e                  mode;
    logic                            btn_prev;
    logic                            phase;
    logic [wbf_pkg::LimitWidth-1:0]  toggles;
    logic [wbf_pkg::PeriodWidth-1:0] ticks;
    logic                            timed_out;
    logic                            green;
    logic                            red;
    led_word_t                       pending_leds[$];
    int                              failures;

    function new();
      wait_ticks   = wbf_pkg::WaitPeriodRst;
      blink_ticks  = wbf_pkg::BlinkPeriodRst;
      toggle_limit = wbf_pkg::BlinkLimitRst;
      mode         = wbf_pkg::MODE_WAITING;
      btn_prev     = 1'b0;
      phase        = 1'b0;
      toggles      = '0;
      ticks        = '0;
      timed_out    = 1'b0;
      green        = 1'b1;
      red          = 1'b0;
      failures     = 0;
    endfunction

    function void write_reg(logic [wbf_pkg::CfgIdxWidth-1:0] idx,
                            logic [wbf_pkg::CfgDataWidth-1:0] data);
      case (idx)
        wbf_pkg::CfgWaitPeriod:  wait_ticks = data;
        wbf_pkg::CfgBlinkPeriod: blink_ticks = data;
        wbf_pkg::CfgBlinkLimit:  toggle_limit = data[wbf_pkg::LimitWidth-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_leds.size();
    endfunction

    function void note_sample(logic level, logic tick_b);
      logic [wbf_pkg::PeriodWidth-1:0] reload;
      led_word_t                       word;
      if (tick_b) begin
        reload = (mode == wbf_pkg::MODE_WAITING) ? wait_ticks : blink_ticks;
        // The compare is >=, so a period lowered below the count wraps at once.
        if (ticks >= reload) begin
          ticks = '0;
          timed_out = 1'b1;
        end else begin
          ticks = ticks + 1'b1;
        end
      end
      if (level && !btn_prev) begin
        btn_prev = 1'b1;
      end else if (!level && btn_prev) begin
        btn_prev = 1'b0;
        if (mode == wbf_pkg::MODE_WAITING) begin
          ticks = '0;
          timed_out = 1'b0;
        end else if (mode == wbf_pkg::MODE_BLINKING) begin
          red = 1'b0;
          green = 1'b1;
          mode = wbf_pkg::MODE_WAITING;
          ticks = '0;
          timed_out = 1'b0;
        end
      end
      case (mode)
        wbf_pkg::MODE_WAITING: begin
          if (timed_out) begin
            green = 1'b0;
            mode = wbf_pkg::MODE_BLINKING;
            toggles = '0;
            timed_out = 1'b0;
          end
        end
        wbf_pkg::MODE_BLINKING: begin
          if (timed_out) begin
            timed_out = 1'b0;
            // The phase survives a return to waiting, red does not.
            phase = ~phase;
            red = phase;
            toggles = toggles + 1'b1;
            if (toggles >= toggle_limit) begin
              mode = wbf_pkg::MODE_FROZEN;
              red = 1'b1;
            end
          end
        end
        default: ;
      endcase
      word.green = green;
      word.red = red;
      case (mode)
        wbf_pkg::MODE_WAITING:  word.mode = wbf_pkg::ModeCodeWaiting;
        wbf_pkg::MODE_BLINKING: word.mode = wbf_pkg::ModeCodeBlinking;
        default:                word.mode = wbf_pkg::ModeCodeFrozen;
      endcase
      pending_leds.push_back(word);
    endfunction

    function void check_result(logic [7:0] tdata);
      led_word_t want;
      if (pending_leds.size() == 0) begin
        $error("unexpected result word %h", tdata);
        failures++;
        return;
      end
      want = pending_leds.pop_front();
      if (tdata[0] !== want.green) begin
        $error("green_on: expected %0d, actual %0d", want.green, tdata[0]);
        failures++;
      end
      if (tdata[1] !== want.red) begin
        $error("red_led: expected %0d, actual %0d", want.red, tdata[1]);
        failures++;
      end
      if (tdata[3:2] !== want.mode) begin
        $error("mode: expected %0d, actual %0d", want.mode, tdata[3:2]);
        failures++;
      end
    endfunction
  endclass

  logic                             clk_i = 1'b0;
  logic                             rst_ni;
  logic                             cfg_we_i;
  logic [wbf_pkg::CfgIdxWidth-1:0]  cfg_index_i;
  logic [wbf_pkg::CfgDataWidth-1:0] cfg_wdata_i;
  logic                             s_axis_tvalid;
  logic                             s_axis_tready;
  logic [7:0]                       s_axis_tdata;   // [0] button_level, [1] tick
  logic                             m_axis_tvalid;
  logic                             m_axis_tready;
  logic [7:0]                       m_axis_tdata;   // [0] green_on, [1] red_led, [3:2] mode

  blink_checker sb;
  int           send_idle_pct;
  int           recv_idle_pct;
  int           stall_cycles;
  logic         btn_held;

  watchdog_blink_freeze_fsm u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  // Result side: check accepted words, then pick the next ready level.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata);
    end
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Leaves tvalid high after the handshake so the next word can follow
  // without a bubble; an idle cycle lowers it.
  task automatic send_sample(input logic level, input logic tick_b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, tick_b, level};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_sample(level, tick_b);
  endtask

  task automatic settle_outputs();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Writes all three registers plus the unused index, with junk in the
  // upper data bits of the limit.
  task automatic set_regs(input logic [15:0] wait_v, input logic [15:0] blink_v,
                          input logic [7:0] limit_v);
    logic [wbf_pkg::CfgIdxWidth-1:0]  idx[4];
    logic [wbf_pkg::CfgDataWidth-1:0] val[4];
    idx = '{wbf_pkg::CfgWaitPeriod, wbf_pkg::CfgBlinkPeriod, wbf_pkg::CfgBlinkLimit,
            CfgUnusedIdx};
    val = '{wait_v, blink_v, {8'($urandom), limit_v}, 16'($urandom)};
    for (int k = 0; k < 4; k++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= idx[k];
      cfg_wdata_i <= val[k];
      @(posedge clk_i);
      sb.write_reg(idx[k], val[k]);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_random(input int count, input int tick_pct, input int toggle_pm);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 999) < toggle_pm) btn_held = ~btn_held;
      send_sample(btn_held, $urandom_range(0, 99) < tick_pct);
    end
  endtask

  initial begin
    int wait_cfg[NumPhases]   = '{3, 0, 1, 7, 12, 2, 0, 4};
    int blink_cfg[NumPhases]  = '{2, 0, 5, 1, 65535, 3, 0, 2};
    int limit_cfg[NumPhases]  = '{255, 200, 255, 255, 255, 128, 255, 0};
    int tick_cfg[NumPhases]   = '{70, 50, 90, 100, 80, 60, 75, 80};
    int toggle_cfg[NumPhases] = '{30, 40, 20, 15, 25, 30, 30, 8};
    sb = new();
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= wbf_pkg::CfgWaitPeriod;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    m_axis_tready <= 1'b0;
    send_idle_pct = 25;
    recv_idle_pct = 81;
    btn_held      = 1'b0;
    wait_cfg[6]  = $urandom_range(0, 10);
    blink_cfg[6] = $urandom_range(0, 6);
    // The last phase freezes the block for good, so its limit is small.
    limit_cfg[7] = $urandom_range(0, 8);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: press and release while waiting restarts the timer.
    send_sample(1'b0, 1'b0);
    send_sample(1'b1, 1'b0);
    send_sample(1'b1, 1'b1);
    send_sample(1'b0, 1'b1);
    send_sample(1'b0, 1'b1);
    send_sample(1'b1, 1'b1);
    send_sample(1'b0, 1'b0);
    settle_outputs();

    // Longest periods, then shrink the wait period below the running count.
    set_regs(16'hFFFF, 16'hFFFF, 8'hFF);
    repeat (4) send_sample(1'b0, 1'b1);
    settle_outputs();
    set_regs(16'd2, 16'd0, 8'hFF);
    send_sample(1'b0, 1'b1);
    // Zero blink period: every tick toggles red.
    repeat (3) send_sample(1'b0, 1'b1);
    // Release during blinking goes back to waiting with red off.
    send_sample(1'b1, 1'b0);
    send_sample(1'b0, 1'b0);
    // Blink again; the kept phase holds red off for the first toggle.
    repeat (3) send_sample(1'b0, 1'b1);
    repeat (2) send_sample(1'b0, 1'b1);
    settle_outputs();

    for (int p = 0; p < NumPhases; p++) begin
      if (p < 3) begin
        send_idle_pct = 25;
        recv_idle_pct = 81;
      end else if (p < 6) begin
        send_idle_pct = 81;
        recv_idle_pct = 25;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_regs(16'(wait_cfg[p]), 16'(blink_cfg[p]), 8'(limit_cfg[p]));
      run_random(230, tick_cfg[p], toggle_cfg[p]);
      settle_outputs();
    end

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/wbf_pkg.sv
hw/rtl/wbf_step.sv
hw/rtl/watchdog_blink_freeze_fsm.sv
tb/sv/tb_top.sv
